### hw/rtl/tcfc_pkg.sv
package tcfc_pkg;

   typedef struct packed {
      logic [31:0] component_in;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [31:0] component_out;
      logic        last_out;
      logic        unsupported;
   } rsp_type;

   localparam int MODE_W = 5;

   localparam logic [MODE_W-1:0] MODE_PASS    = 5'd0;
   localparam logic [MODE_W-1:0] MODE_F2UN8   = 5'd1;
   localparam logic [MODE_W-1:0] MODE_UN82F   = 5'd2;
   localparam logic [MODE_W-1:0] MODE_F2SN8   = 5'd3;
   localparam logic [MODE_W-1:0] MODE_SN82F   = 5'd4;
   localparam logic [MODE_W-1:0] MODE_F2UN16  = 5'd5;
   localparam logic [MODE_W-1:0] MODE_UN162F  = 5'd6;
   localparam logic [MODE_W-1:0] MODE_F2SN16  = 5'd7;
   localparam logic [MODE_W-1:0] MODE_SN162F  = 5'd8;
   localparam logic [MODE_W-1:0] MODE_U32_U16 = 5'd9;
   localparam logic [MODE_W-1:0] MODE_U16_U32 = 5'd10;
   localparam logic [MODE_W-1:0] MODE_U32_U8  = 5'd11;
   localparam logic [MODE_W-1:0] MODE_U8_U32  = 5'd12;
   localparam logic [MODE_W-1:0] MODE_I32_I16 = 5'd13;
   localparam logic [MODE_W-1:0] MODE_I16_I32 = 5'd14;
   localparam logic [MODE_W-1:0] MODE_I32_I8  = 5'd15;
   localparam logic [MODE_W-1:0] MODE_I8_I32  = 5'd16;
   localparam logic [MODE_W-1:0] MODE_H2F     = 5'd17;
   localparam logic [MODE_W-1:0] MODE_F2H     = 5'd18;

   localparam int PROD_W = 40;
   localparam int FRAC_W = 48;
   localparam int INT_W  = 18;
   localparam int SUM_W  = INT_W + FRAC_W;

   localparam logic [7:0] EXP_TINY = 8'd102;
   localparam logic [7:0] EXP_BIG  = 8'd128;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              unsup;
      logic              scale;
      logic              wide;
      logic              sign;
      logic              nan;
      logic              big;
      logic              tiny;
      logic [7:0]        expo;
      logic [PROD_W-1:0] prod;
      logic [14:0]       cadd;
      logic [31:0]       direct;
   } s1_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              unsup;
      logic              scale;
      logic              wide;
      logic              sign;
      logic              nan;
      logic              big;
      logic              neg;
      logic [INT_W-1:0]  intp;
      logic [FRAC_W-1:0] frac;
      logic [31:0]       direct;
   } s3_type;

   function automatic logic [3:0] lead_pos(input logic [15:0] v);
      logic [3:0] pos;
      pos = '0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            pos = 4'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  p;
      logic [10:0] tmp;
      logic [7:0]  en;
      logic [31:0] r;
      e   = h[14:10];
      m   = h[9:0];
      p   = lead_pos({6'b0, m});
      tmp = {1'b0, m} << (4'd10 - p);
      en  = 8'd103 + {4'b0, p};
      if (e == 5'd0) begin
         if (m == 10'd0) begin
            r = {h[15], 31'b0};
         end else begin
            r = {h[15], en, tmp[9:0], 13'b0};
         end
      end else if (e == 5'h1f) begin
         r = {h[15], 8'hff, m, 13'b0};
      end else begin
         r = {h[15], 8'({3'b0, e} + 8'd112), m, 13'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] single_to_half(input logic [31:0] u);
      logic        s;
      logic [30:0] a;
      logic [30:0] b;
      logic [9:0]  mq;
      logic [7:0]  e;
      logic [24:0] m;
      logic [4:0]  sh;
      logic [24:0] r;
      logic [24:0] rem;
      logic [24:0] half;
      logic [15:0] o;
      s    = u[31];
      a    = u[30:0];
      mq   = a[22:13];
      e    = a[30:23];
      m    = {2'b01, a[22:0]};
      sh   = 5'(8'd126 - e);
      r    = m >> sh;
      rem  = m & ((25'd1 << sh) - 25'd1);
      half = 25'd1 << (sh - 5'd1);
      b    = a - 31'h38000000;
      b    = (b + 31'hfff + {30'b0, b[13]}) >> 13;
      if (a >= 31'h7f800000) begin
         if (a == 31'h7f800000) begin
            o = {s, 15'h7c00};
         end else begin
            o = {s, 5'h1f, mq | {9'b0, (mq == 10'd0)}};
         end
      end else if (a > 31'h477fefff) begin
         o = {s, 15'h7c00};
      end else if (a < 31'h33000001) begin
         o = {s, 15'b0};
      end else if (a < 31'h38800000) begin
         if (rem > half || (rem == half && r[0])) begin
            r = r + 25'd1;
         end
         o = {s, r[14:0]};
      end else begin
         o = {s, b[14:0]};
      end
      return {16'b0, o};
   endfunction

   // The quotient c/(2^n - 1) is the n-bit code repeated forever, so it never
   // lands on a rounding tie and the round bit alone decides.
   function automatic logic [31:0] unorm_to_float(input logic [15:0] c, input logic wide);
      logic [15:0] v;
      logic [3:0]  p;
      logic [3:0]  lz;
      logic [47:0] w;
      logic [47:0] ws;
      logic [31:0] r;
      v  = wide ? c : {8'b0, c[7:0]};
      p  = lead_pos(v);
      lz = wide ? 4'(4'd15 - p) : 4'(4'd7 - p);
      w  = wide ? {3{v}} : {6{v[7:0]}};
      ws = w << lz;
      r  = {1'b0, 8'(8'd126 - {4'b0, lz}), ws[46:24]} + {31'b0, ws[23]};
      return (v == 16'd0) ? 32'd0 : r;
   endfunction

   function automatic logic [31:0] snorm_to_float(input logic [15:0] c, input logic wide);
      logic signed [17:0] d;
      logic [17:0]        dm;
      logic [15:0]        mag;
      logic [3:0]         p;
      logic [23:0]        sm;
      logic [7:0]         ex;
      d   = wide ? ($signed({2'b0, c}) - 18'sd32767)
                 : ($signed({10'b0, c[7:0]}) - 18'sd127);
      dm  = d[17] ? 18'(-d) : 18'(d);
      mag = dm[15:0];
      p   = lead_pos(mag);
      sm  = 24'(mag) << (5'd23 - {1'b0, p});
      ex  = 8'd127 + {4'b0, p} - (wide ? 8'd15 : 8'd7);
      return (mag == 16'd0) ? 32'd0 : {d[17], ex, sm[22:0]};
   endfunction

endpackage

### hw/rtl/tcfc_decode.sv
module tcfc_decode import tcfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [MODE_W-1:0] mode,
   input  logic              in_valid,
   input  req_type           req,
   output s1_type            s1
);

   s1_type      s1_ff;
   s1_type      s1_in;
   logic [31:0] c;
   logic [15:0] kmul;
   logic [23:0] mant;

   assign c    = req.component_in;
   assign mant = {1'b1, c[22:0]};

   always_comb begin
      s1_in        = '0;
      kmul         = '0;
      s1_in.valid  = in_valid;
      s1_in.last   = req.last_in;
      s1_in.sign   = c[31];
      s1_in.expo   = c[30:23];
      s1_in.nan    = (c[30:23] == 8'hff) && (c[22:0] != 23'd0);
      s1_in.big    = (c[30:23] >= EXP_BIG) && !s1_in.nan;
      s1_in.tiny   = c[30:23] < EXP_TINY;
      unique case (mode) inside
         MODE_PASS: begin
            s1_in.direct = c;
         end
         MODE_F2UN8: begin
            s1_in.scale = 1'b1;
            kmul        = 16'd255;
         end
         MODE_UN82F: begin
            s1_in.direct = unorm_to_float(c[15:0], 1'b0);
         end
         MODE_F2SN8: begin
            s1_in.scale = 1'b1;
            kmul        = 16'd128;
            s1_in.cadd  = 15'd127;
         end
         MODE_SN82F: begin
            s1_in.direct = snorm_to_float(c[15:0], 1'b0);
         end
         MODE_F2UN16: begin
            s1_in.scale = 1'b1;
            s1_in.wide  = 1'b1;
            kmul        = 16'd65535;
         end
         MODE_UN162F: begin
            s1_in.direct = unorm_to_float(c[15:0], 1'b1);
         end
         MODE_F2SN16: begin
            s1_in.scale = 1'b1;
            s1_in.wide  = 1'b1;
            kmul        = 16'd32768;
            s1_in.cadd  = 15'd32767;
         end
         MODE_SN162F: begin
            s1_in.direct = snorm_to_float(c[15:0], 1'b1);
         end
         MODE_U32_U16, MODE_U16_U32, MODE_I32_I16: begin
            s1_in.direct = {16'b0, c[15:0]};
         end
         MODE_U32_U8, MODE_U8_U32, MODE_I32_I8: begin
            s1_in.direct = {24'b0, c[7:0]};
         end
         MODE_I16_I32: begin
            s1_in.direct = {{16{c[15]}}, c[15:0]};
         end
         MODE_I8_I32: begin
            s1_in.direct = {{24{c[7]}}, c[7:0]};
         end
         MODE_H2F: begin
            s1_in.direct = half_to_single(c[15:0]);
         end
         MODE_F2H: begin
            s1_in.direct = single_to_half(c);
         end
         default: begin
            s1_in.unsup = 1'b1;
         end
      endcase
      s1_in.prod = {16'b0, mant} * {24'b0, kmul};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

   assert property (@(posedge clock) disable iff (reset)
      in_valid && (mode == MODE_F2UN8) |=> s1_ff.valid && s1_ff.scale && !s1_ff.wide)
      else $error("Scale path not selected for an fp32 to unorm8 transaction.");

endmodule

### hw/rtl/tcfc_align.sv
module tcfc_align import tcfc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  s1_type s1,
   output s3_type s3
);

   typedef struct packed {
      logic             valid;
      logic             last;
      logic             unsup;
      logic             scale;
      logic             wide;
      logic             sign;
      logic             nan;
      logic             big;
      logic [14:0]      cadd;
      logic [SUM_W-1:0] tfix;
      logic [31:0]      direct;
   } s2_type;

   s2_type         s2_ff;
   s2_type         s2_in;
   s3_type         s3_ff;
   s3_type         s3_in;
   logic [4:0]     sh;
   logic [SUM_W-1:0] cfix;
   logic [SUM_W:0] sum;

   assign sh = 5'(s1.expo - EXP_TINY);

   always_comb begin
      s2_in.valid  = s1.valid;
      s2_in.last   = s1.last;
      s2_in.unsup  = s1.unsup;
      s2_in.scale  = s1.scale;
      s2_in.wide   = s1.wide;
      s2_in.sign   = s1.sign;
      s2_in.nan    = s1.nan;
      s2_in.big    = s1.big;
      s2_in.cadd   = s1.cadd;
      s2_in.direct = s1.direct;
      if (s1.tiny || s1.big || s1.nan) begin
         s2_in.tfix = '0;
      end else begin
         s2_in.tfix = SUM_W'(s1.prod) << sh;
      end
   end

   assign cfix = {{(INT_W-15){1'b0}}, s2_ff.cadd, {FRAC_W{1'b0}}};

   always_comb begin
      if (s2_ff.sign) begin
         sum = {1'b0, cfix} - {1'b0, s2_ff.tfix};
      end else begin
         sum = {1'b0, cfix} + {1'b0, s2_ff.tfix};
      end
      s3_in.valid  = s2_ff.valid;
      s3_in.last   = s2_ff.last;
      s3_in.unsup  = s2_ff.unsup;
      s3_in.scale  = s2_ff.scale;
      s3_in.wide   = s2_ff.wide;
      s3_in.sign   = s2_ff.sign;
      s3_in.nan    = s2_ff.nan;
      s3_in.big    = s2_ff.big;
      s3_in.neg    = sum[SUM_W];
      s3_in.intp   = sum[SUM_W-1:FRAC_W];
      s3_in.frac   = sum[FRAC_W-1:0];
      s3_in.direct = s2_ff.direct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

### hw/rtl/tcfc_quant.sv
module tcfc_quant import tcfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  s3_type  s3,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   logic [4:0]        pos;
   logic [5:0]        j;
   logic [FRAC_W-1:0] mask;
   logic              carry;
   logic [INT_W:0]    val;
   logic [15:0]       maxv;
   logic [15:0]       q;

   always_comb begin
      pos = '0;
      for (int i = 0; i < INT_W; i++) begin
         if (s3.intp[i]) begin
            pos = 5'(i);
         end
      end
   end

   // The sum rounds up to the next integer when its fraction lies within
   // half a unit in the last place of that integer.
   assign j     = (s3.intp == '0) ? 6'd23 : ({1'b0, pos} + 6'd24);
   assign mask  = (FRAC_W'(1) << j) - FRAC_W'(1);
   assign carry = &(s3.frac | mask);
   assign val   = {1'b0, s3.intp} + {{INT_W{1'b0}}, carry};
   assign maxv  = s3.wide ? 16'hffff : 16'h00ff;

   always_comb begin
      if (s3.nan || s3.neg) begin
         q = '0;
      end else if (s3.big) begin
         q = s3.sign ? 16'd0 : maxv;
      end else if (val >= {3'b0, maxv}) begin
         q = maxv;
      end else begin
         q = val[15:0];
      end
      rsp_in.last_out    = s3.last;
      rsp_in.unsupported = s3.unsup;
      if (s3.unsup) begin
         rsp_in.component_out = '0;
      end else if (s3.scale) begin
         rsp_in.component_out = {16'b0, q};
      end else begin
         rsp_in.component_out = s3.direct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.unsupported |-> rsp_ff.component_out == 32'd0)
      else $error("Unsupported transaction carries a nonzero component.");

   assert property (@(posedge clock) disable iff (reset)
      s3.valid && s3.scale && !s3.wide |=> rsp_ff.component_out[31:8] == 24'd0)
      else $error("Eight-bit quantized result exceeds its range.");

   assert property (@(posedge clock) disable iff (reset)
      s3.valid && s3.scale && s3.nan |=> rsp_ff.component_out == 32'd0)
      else $error("NaN did not quantize to zero.");

endmodule

### hw/rtl/texel_component_format_converter_core.sv
// Channel   Handshake           Payload       Direction
// request   start / busy        req_payload   in
// response  rsp_valid (strobe)  rsp_payload   out
// config    csr_we              csr_wdata     in
//
// One transaction is accepted in every cycle; busy is always low.
// Each result leaves through the four register stages after its transaction is
// accepted: decode and multiply, align, offset add, quantize.
// Reset clears the mode register to pass-through and empties the pipeline.
// The receiver cannot stall, so the pipeline never holds back.
module texel_component_format_converter_core import tcfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_valid,
   output rsp_type           rsp_payload,
   input  logic              csr_we,
   input  logic [MODE_W-1:0] csr_wdata
);

   logic [MODE_W-1:0] mode_ff;
   s1_type            s1;
   s3_type            s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   tcfc_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .in_valid (start),
      .req      (req_payload),
      .s1       (s1)
   );

   tcfc_align u_align (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .s3    (s3)
   );

   tcfc_quant u_quant (
      .clock       (clock),
      .reset       (reset),
      .s3          (s3),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("Response strobe without a matching accepted transaction.");

endmodule

### sim/tb_texel_component_format_converter_core.sv
`timescale 1ns / 100ps

module tb_texel_component_format_converter_core;
   import tcfc_pkg::*;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              csr_we;
   logic [MODE_W-1:0] csr_wdata;

   texel_component_format_converter_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   req_type           pending_q[$];
   rsp_type           converted_q[$];
   logic [MODE_W-1:0] active_mode;
   logic              took;
   logic              no_gaps;
   int                gap_cnt;
   int                mismatches = 0;
   int                stall_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic real f32_to_real(input logic [31:0] b);
      real v;
      if (b[30:23] == 8'd0) begin
         v = real'(b[22:0]) / (2.0 ** 149);
         return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'b0});
   endfunction

   // Rounds a double to the nearest single-precision value, ties to even.
   // Values below the normal single range are left as they are; they are only
   // ever lost in a later offset add or in a truncation to an integer.
   function automatic real round_single(input real x);
      logic [63:0] d;
      logic [28:0] rem;
      d = $realtobits(x);
      if (d[62:52] < 11'd897) begin
         return x;
      end
      rem = d[28:0];
      d[28:0] = '0;
      if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && d[29])) begin
         d = d + (64'd1 << 29);
      end
      return $bitstoreal(d);
   endfunction

   function automatic logic [31:0] real_to_f32(input real x);
      logic [63:0] d;
      d = $realtobits(round_single(x));
      if (d[62:0] == 63'd0) begin
         return {d[63], 31'b0};
      end
      return {d[63], 8'(d[62:52] - 11'd896), d[51:29]};
   endfunction

   function automatic logic [31:0] saturate(input real t, input int maxv);
      if (!(t > 0.0)) begin
         return 32'd0;
      end
      if (t >= real'(maxv)) begin
         return 32'(maxv);
      end
      return 32'($rtoi(t));
   endfunction

   function automatic logic [31:0] float_to_norm(input logic [31:0] c, input logic signed_code,
                                                 input logic wide);
      int  maxv;
      real t;
      maxv = wide ? 65535 : 255;
      if (c[30:23] == 8'hff) begin
         if (c[22:0] != 23'd0 || c[31]) begin
            return 32'd0;
         end
         return 32'(maxv);
      end
      if (signed_code) begin
         t = round_single(f32_to_real(c) * (wide ? 32768.0 : 128.0));
         t = round_single(t + (wide ? 32767.0 : 127.0));
      end else begin
         t = round_single(f32_to_real(c) * real'(maxv));
      end
      return saturate(t, maxv);
   endfunction

   function automatic logic [31:0] expand_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [31:0] e;
      logic [31:0] m;
      sgn = {h[15], 31'b0};
      e = 32'(h[14:10]);
      m = 32'(h[9:0]);
      if (e == 0) begin
         if (m == 0) begin
            return sgn;
         end
         e = 113;
         while (m[10] == 1'b0) begin
            m = m << 1;
            e = e - 1;
         end
         return sgn | (e << 23) | ((m & 32'h3ff) << 13);
      end
      if (e == 31) begin
         return sgn | 32'h7f80_0000 | (m << 13);
      end
      return sgn | ((e + 112) << 23) | (m << 13);
   endfunction

   function automatic logic [31:0] narrow_to_half(input logic [31:0] u);
      logic [31:0] sgn;
      logic [31:0] a;
      logic [31:0] m;
      logic [31:0] sh;
      logic [31:0] r;
      logic [31:0] rem;
      logic [31:0] halfway;
      sgn = {16'b0, u[31], 15'b0};
      a = {1'b0, u[30:0]};
      if (a >= 32'h7f80_0000) begin
         if (a == 32'h7f80_0000) begin
            return sgn | 32'h7c00;
         end
         m = (a & 32'h7f_ffff) >> 13;
         return sgn | 32'h7c00 | m | ((m == 0) ? 32'd1 : 32'd0);
      end
      if (a > 32'h477f_efff) begin
         return sgn | 32'h7c00;
      end
      if (a < 32'h3300_0001) begin
         return sgn;
      end
      if (a < 32'h3880_0000) begin
         m = (a & 32'h7f_ffff) | 32'h80_0000;
         sh = 126 - (a >> 23);
         r = m >> sh;
         rem = m & ((32'd1 << sh) - 1);
         halfway = 32'd1 << (sh - 1);
         if (rem > halfway || (rem == halfway && r[0])) begin
            r = r + 1;
         end
         return sgn | r;
      end
      a = a - 32'h3800_0000;
      a = (a + 32'hfff + ((a >> 13) & 32'd1)) >> 13;
      return sgn | a;
   endfunction

   function automatic rsp_type predict_rsp(input req_type q, input logic [MODE_W-1:0] md);
      rsp_type     o;
      logic [31:0] c;
      c = q.component_in;
      o.component_out = 32'd0;
      o.last_out = q.last_in;
      o.unsupported = 1'b0;
      case (md)
         MODE_PASS:    o.component_out = c;
         MODE_F2UN8:   o.component_out = float_to_norm(c, 1'b0, 1'b0);
         MODE_UN82F:   o.component_out = real_to_f32(real'(c[7:0]) / 255.0);
         MODE_F2SN8:   o.component_out = float_to_norm(c, 1'b1, 1'b0);
         MODE_SN82F:   o.component_out = real_to_f32((real'(c[7:0]) - 127.0) / 128.0);
         MODE_F2UN16:  o.component_out = float_to_norm(c, 1'b0, 1'b1);
         MODE_UN162F:  o.component_out = real_to_f32(real'(c[15:0]) / 65535.0);
         MODE_F2SN16:  o.component_out = float_to_norm(c, 1'b1, 1'b1);
         MODE_SN162F:  o.component_out = real_to_f32((real'(c[15:0]) - 32767.0) / 32768.0);
         MODE_U32_U16, MODE_U16_U32, MODE_I32_I16: o.component_out = {16'b0, c[15:0]};
         MODE_U32_U8, MODE_U8_U32, MODE_I32_I8:    o.component_out = {24'b0, c[7:0]};
         MODE_I16_I32: o.component_out = {{16{c[15]}}, c[15:0]};
         MODE_I8_I32:  o.component_out = {{24{c[7]}}, c[7:0]};
         MODE_H2F:     o.component_out = expand_half(c[15:0]);
         MODE_F2H:     o.component_out = narrow_to_half(c);
         default:      o.unsupported = 1'b1;
      endcase
      return o;
   endfunction

   function automatic logic [31:0] random_component(input logic [MODE_W-1:0] md);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         case ($urandom_range(0, 5))
            0: return 32'h7f80_0000 | {1'($urandom_range(0, 1)), 31'b0};
            1: return {1'($urandom_range(0, 1)), 8'hff, 23'($urandom_range(1, 32'h7f_ffff))};
            2: return {1'($urandom_range(0, 1)), 31'b0};
            3: return 32'hffff_ffff;
            4: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom())};
            default: return $urandom();
         endcase
      end
      if (pick < 3) begin
         return $urandom();
      end
      if (md == MODE_F2H) begin
         return {1'($urandom()), 8'($urandom_range(98, 145)), 23'($urandom())};
      end
      if (md == MODE_F2UN8 || md == MODE_F2SN8 || md == MODE_F2UN16 || md == MODE_F2SN16) begin
         if (pick < 6) begin
            return {1'($urandom()), 8'($urandom_range(100, 128)), 23'($urandom())};
         end
         return {1'b0, 8'($urandom_range(119, 126)), 23'($urandom())};
      end
      return $urandom();
   endfunction

   always @(posedge clock) begin
      took <= !reset && start && !busy;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && !busy) begin
            converted_q.push_back(predict_rsp(req_payload, active_mode));
         end
         if (rsp_valid) begin
            if (converted_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) begin
                  $display("Unexpected transaction: %h", rsp_payload);
               end
            end else begin
               if (rsp_payload.component_out !== converted_q[0].component_out
                   || rsp_payload.last_out !== converted_q[0].last_out
                   || rsp_payload.unsupported !== converted_q[0].unsupported) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("Mismatch in mode %0d: expected %h/%b/%b, actual %h/%b/%b",
                              active_mode, converted_q[0].component_out,
                              converted_q[0].last_out, converted_q[0].unsupported,
                              rsp_payload.component_out, rsp_payload.last_out,
                              rsp_payload.unsupported);
                  end
               end
               void'(converted_q.pop_front());
            end
         end
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= 2000) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_payload <= '0;
         gap_cnt <= 0;
      end else if (!(start && !took)) begin
         if (pending_q.size() != 0 && (gap_cnt == 0 || no_gaps)) begin
            req_payload <= pending_q.pop_front();
            start <= 1'b1;
            gap_cnt <= $urandom_range(0, 15);
         end else begin
            start <= 1'b0;
            if (gap_cnt > 0) begin
               gap_cnt <= gap_cnt - 1;
            end
         end
      end
   end

   task automatic set_mode(input logic [MODE_W-1:0] md);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= md;
      active_mode = md;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      do begin
         @(negedge clock);
      end while (pending_q.size() != 0 || start || converted_q.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic send(input logic [31:0] c);
      req_type q;
      q.component_in = c;
      q.last_in = 1'($urandom());
      pending_q.push_back(q);
   endtask

   initial begin
      logic [MODE_W-1:0] md;
      int                count;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      active_mode = MODE_PASS;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send(32'hffff_ffff);
      send(32'h0000_0000);
      drain();
      set_mode(MODE_F2UN8);
      send(32'h7fc0_0001);
      send(32'h7f80_0000);
      send(32'hff80_0000);
      send(32'h3f80_0000);
      send(32'h7f7f_ffff);
      drain();
      set_mode(MODE_F2SN16);
      send(32'hffc0_0000);
      send(32'hbf80_0000);
      send(32'h3f80_0000);
      send(32'h0000_0001);
      drain();
      set_mode(MODE_F2H);
      send(32'h7f80_0001);
      send(32'h477f_f000);
      send(32'h3300_0001);
      send(32'h3880_0000);
      drain();
      set_mode(MODE_H2F);
      send(32'h0000_0001);
      send(32'h0000_fc01);
      drain();
      set_mode(MODE_SN82F);
      send(32'h0000_0000);
      send(32'h0000_00ff);
      drain();
      set_mode(5'd31);
      send(32'h1234_5678);
      drain();

      for (int ph = 0; ph < 50; ph++) begin
         if (ph < 32) begin
            md = 5'(ph);
         end else begin
            md = 5'($urandom_range(0, 19));
         end
         set_mode(md);
         no_gaps = ($urandom_range(0, 3) == 0);
         count = $urandom_range(20, 60);
         for (int i = 0; i < count; i++) begin
            send(random_component(md));
         end
         drain();
      end

      set_mode(MODE_PASS);
      drain();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/tcfc_pkg.sv
hw/rtl/tcfc_decode.sv
hw/rtl/tcfc_align.sv
hw/rtl/tcfc_quant.sv
hw/rtl/texel_component_format_converter_core.sv
sim/tb_texel_component_format_converter_core.sv
